/* design/rrp_pkg.sv */
// Shared types, widths and character codes for the RESP reply parser.
package rrp_pkg;

    localparam int LEN_BITS = 32;
    localparam int NUM_W    = (LEN_BITS < 31) ? LEN_BITS : 31;
    localparam int IDX_W    = 31;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_STATUS = 3'd1,
        KIND_ERROR  = 3'd2,
        KIND_INT    = 3'd3,
        KIND_BULK   = 3'd4,
        KIND_MULTI  = 3'd5
    } t_kind;

    typedef enum logic [7:0] {
        PH_TYPE  = 8'b0000_0001,
        PH_LINE  = 8'b0000_0010,
        PH_NUM   = 8'b0000_0100,
        PH_ENUM  = 8'b0000_1000,
        PH_PAY   = 8'b0001_0000,
        PH_PCR   = 8'b0010_0000,
        PH_PLF   = 8'b0100_0000,
        PH_ETYPE = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_status            status;
        t_kind              kind;
        logic               payload;
        logic [IDX_W-1:0]   index;
    } t_result;

endpackage

/* design/rrp_in_if.sv */
// Input channel: one stream byte per word.
interface rrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* design/rrp_out_if.sv */
// Output channel: per-byte parse result word.
interface rrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  parse_status;
    logic [2:0]  reply_kind;
    logic        payload_byte;
    logic [30:0] element_index;

    modport source (output valid, output parse_status, output reply_kind,
                    output payload_byte, output element_index, input ready);
    modport sink   (input valid, input parse_status, input reply_kind,
                    input payload_byte, input element_index, output ready);
endinterface

/* design/rrp_digit.sv */
// Decimal digit accumulator step with magnitude overflow detection.
module rrp_digit
    import rrp_pkg::*;
(
    input  logic [NUM_W-1:0] i_accum,
    input  logic [3:0]       i_digit,
    output logic [NUM_W-1:0] o_accum,
    output logic             o_ovf
);

    logic [NUM_W+3:0] w_ext;
    logic [NUM_W+3:0] w_sum;

    assign w_ext   = {4'b0000, i_accum};
    assign w_sum   = (w_ext << 3) + (w_ext << 1) + {{NUM_W{1'b0}}, i_digit};
    assign o_accum = w_sum[NUM_W-1:0];
    assign o_ovf   = (w_sum[NUM_W+3:NUM_W] != 4'd0);

endmodule

/* design/rrp_fsm.sv */
// Parser state registers and the per-byte next-state and result logic.
module rrp_fsm
    import rrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    t_phase             r_phase, n_phase;
    t_kind              r_kind, n_kind;
    logic [NUM_W-1:0]   r_accum, n_accum;
    logic               r_neg, n_neg;
    logic               r_digit, n_digit;
    logic               r_cr, n_cr;
    logic [NUM_W-1:0]   r_left, n_left;
    logic [IDX_W-1:0]   r_count, n_count;
    logic [NUM_W-1:0]   r_pay_left, n_pay_left;

    t_status            w_st;
    logic               w_pay;
    logic [NUM_W-1:0]   w_dig_accum;
    logic               w_dig_ovf;
    logic               w_is_digit;
    logic               w_neg_val;
    logic               w_is_one;
    logic [NUM_W-1:0]   w_left_dec;

    rrp_digit u_digit (
        .i_accum (r_accum),
        .i_digit (i_byte[3:0]),
        .o_accum (w_dig_accum),
        .o_ovf   (w_dig_ovf)
    );

    assign w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_neg_val  = r_neg && (r_accum != '0);
    assign w_is_one   = (r_accum == NUM_W'(1));
    assign w_left_dec = (r_left != '0) ? r_left - NUM_W'(1) : '0;

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_accum    = r_accum;
        n_neg      = r_neg;
        n_digit    = r_digit;
        n_cr       = r_cr;
        n_left     = r_left;
        n_count    = r_count;
        n_pay_left = r_pay_left;
        w_st       = ST_RUN;
        w_pay      = 1'b0;

        unique case (r_phase)
            PH_LINE: begin
                if (r_cr && (i_byte == CH_LF)) begin
                    w_st = ST_DONE;
                end else begin
                    n_cr = (i_byte == CH_CR);
                end
            end
            PH_NUM, PH_ENUM: begin
                if (r_cr) begin
                    if (i_byte != CH_LF) begin
                        w_st = ST_ERR;
                    end else if ((r_phase == PH_ENUM) && w_neg_val) begin
                        if (!w_is_one) begin
                            w_st = ST_ERR;
                        end else begin
                            n_count = r_count + IDX_W'(1);
                            n_left  = w_left_dec;
                            if (w_left_dec == '0) begin
                                w_st = ST_DONE;
                            end else begin
                                n_phase = PH_ETYPE;
                            end
                        end
                    end else if ((r_phase == PH_ENUM) || (r_kind == KIND_BULK)) begin
                        if (w_neg_val) begin
                            w_st = w_is_one ? ST_DONE : ST_ERR;
                        end else begin
                            n_pay_left = r_accum;
                            n_phase    = (r_accum != '0) ? PH_PAY : PH_PCR;
                            n_cr       = 1'b0;
                        end
                    end else if (r_kind == KIND_INT) begin
                        w_st = ST_DONE;
                    end else if (r_kind == KIND_MULTI) begin
                        if (w_neg_val) begin
                            w_st = w_is_one ? ST_DONE : ST_ERR;
                        end else if (r_accum == '0) begin
                            w_st = ST_DONE;
                        end else begin
                            n_left  = r_accum;
                            n_count = '0;
                            n_phase = PH_ETYPE;
                            n_accum = '0;
                            n_neg   = 1'b0;
                            n_digit = 1'b0;
                            n_cr    = 1'b0;
                        end
                    end else begin
                        w_st = ST_ERR;
                    end
                end else if (i_byte == CH_CR) begin
                    if (!r_digit) begin
                        w_st = ST_ERR;
                    end else begin
                        n_cr = 1'b1;
                    end
                end else if ((i_byte == CH_MINUS) && !r_digit && !r_neg) begin
                    n_neg = 1'b1;
                end else if (w_is_digit) begin
                    if (w_dig_ovf) begin
                        w_st = ST_ERR;
                    end else begin
                        n_accum = w_dig_accum;
                        n_digit = 1'b1;
                    end
                end else begin
                    w_st = ST_ERR;
                end
            end
            PH_PAY: begin
                w_pay      = 1'b1;
                n_pay_left = (r_pay_left != '0) ? r_pay_left - NUM_W'(1) : '0;
                if (n_pay_left == '0) begin
                    n_phase = PH_PCR;
                end
            end
            PH_PCR: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_PLF;
                end else begin
                    w_st = ST_ERR;
                end
            end
            PH_PLF: begin
                if (i_byte != CH_LF) begin
                    w_st = ST_ERR;
                end else if (r_kind == KIND_MULTI) begin
                    n_count = r_count + IDX_W'(1);
                    n_left  = w_left_dec;
                    if (w_left_dec == '0) begin
                        w_st = ST_DONE;
                    end else begin
                        n_phase = PH_ETYPE;
                    end
                end else begin
                    w_st = ST_DONE;
                end
            end
            PH_ETYPE: begin
                if (i_byte == CH_DOLLAR) begin
                    n_accum = '0;
                    n_neg   = 1'b0;
                    n_digit = 1'b0;
                    n_cr    = 1'b0;
                    n_phase = PH_ENUM;
                end else begin
                    w_st = ST_ERR;
                end
            end
            default: begin
                n_accum    = '0;
                n_neg      = 1'b0;
                n_digit    = 1'b0;
                n_cr       = 1'b0;
                n_left     = '0;
                n_count    = '0;
                n_pay_left = '0;
                n_kind     = KIND_NONE;
                n_phase    = PH_TYPE;
                case (i_byte)
                    CH_PLUS: begin
                        n_kind  = KIND_STATUS;
                        n_phase = PH_LINE;
                    end
                    CH_MINUS: begin
                        n_kind  = KIND_ERROR;
                        n_phase = PH_LINE;
                    end
                    CH_COLON: begin
                        n_kind  = KIND_INT;
                        n_phase = PH_NUM;
                    end
                    CH_DOLLAR: begin
                        n_kind  = KIND_BULK;
                        n_phase = PH_NUM;
                    end
                    CH_STAR: begin
                        n_kind  = KIND_MULTI;
                        n_phase = PH_NUM;
                    end
                    default: begin
                        w_st = ST_ERR;
                    end
                endcase
            end
        endcase
    end

    assign o_result.status  = w_st;
    assign o_result.kind    = n_kind;
    assign o_result.payload = w_pay;
    assign o_result.index   = ((r_kind == KIND_MULTI) && (r_phase != PH_NUM)) ? r_count : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && (w_st != ST_RUN))) begin
            r_phase    <= PH_TYPE;
            r_kind     <= KIND_NONE;
            r_accum    <= '0;
            r_neg      <= 1'b0;
            r_digit    <= 1'b0;
            r_cr       <= 1'b0;
            r_left     <= '0;
            r_count    <= '0;
            r_pay_left <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_accum    <= n_accum;
            r_neg      <= n_neg;
            r_digit    <= n_digit;
            r_cr       <= n_cr;
            r_left     <= n_left;
            r_count    <= n_count;
            r_pay_left <= n_pay_left;
        end
    end

endmodule

/* design/resp_reply_parser.sv */
// Top level of the RESP reply parser: input handshake, parser core and result register.
//
//   channel   modport   word contents
//   i_req     sink      data_byte
//   o_rsp     source    parse_status, reply_kind, payload_byte, element_index
//
// Each byte is parsed in the cycle it is accepted, and its result word is
// registered and shown on o_rsp in the next cycle.
// A new byte is accepted in every cycle while the result register is empty or
// being drained, so the sustained rate is one byte per clock.
// When o_rsp stalls, the result register holds and i_req.ready drops.
// Synchronous active-low reset returns the parser to waiting for a type byte.
module resp_reply_parser
    import rrp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrp_in_if.sink        i_req,
    rrp_out_if.source     o_rsp
);

    logic     w_accept;
    t_result  w_result;
    logic     r_out_valid;
    t_result  r_out;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    rrp_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_accept),
        .i_byte   (i_req.data_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_out_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.parse_status  = r_out.status;
    assign o_rsp.reply_kind    = r_out.kind;
    assign o_rsp.payload_byte  = r_out.payload;
    assign o_rsp.element_index = r_out.index;

`ifndef ASSERT_OFF
    a_payload_in_bulk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload_byte) |->
            ((o_rsp.parse_status == ST_RUN) &&
             ((o_rsp.reply_kind == KIND_BULK) || (o_rsp.reply_kind == KIND_MULTI))))
        else $error("payload word outside a running bulk reply");

    a_index_in_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.element_index != '0)) |->
            (o_rsp.reply_kind == KIND_MULTI))
        else $error("element index set outside a multi-bulk reply");

    a_no_kind_is_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.reply_kind == KIND_NONE)) |->
            (o_rsp.parse_status == ST_ERR))
        else $error("word without reply type is not an error");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench for the RESP reply parser: directed script, random replies, predictor.
module tb;
    import rrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PERIOD    = 10;
    localparam logic [63:0] NUM_LIMIT = (LEN_BITS < 31) ? ((64'd1 << LEN_BITS) - 64'd1)
                                                        : 64'h7FFF_FFFF;
    localparam logic        TYPED     = 1'b1;
    localparam logic        PRED      = 1'b0;
    localparam t_result     NO_RES    = '0;
    localparam int          N_ROWS    = 30;
    localparam int          PHASE_BYTES = 290;
    localparam logic [3:0][7:0] SRC_IDLE   = {8'd15, 8'd0, 8'd47, 8'd0};
    localparam logic [3:0][7:0] SINK_STALL = {8'd15, 8'd47, 8'd0, 8'd0};

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        t_result    res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rrp_in_if  req ();
    rrp_out_if rsp ();

    resp_reply_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    t_row script [N_ROWS] = '{
        {CH_PLUS,   TYPED, ST_RUN,  KIND_STATUS, 1'b0, 31'd0},
        {CH_CR,     TYPED, ST_RUN,  KIND_STATUS, 1'b0, 31'd0},
        {"a",       TYPED, ST_RUN,  KIND_STATUS, 1'b0, 31'd0},
        {CH_CR,     TYPED, ST_RUN,  KIND_STATUS, 1'b0, 31'd0},
        {CH_LF,     TYPED, ST_DONE, KIND_STATUS, 1'b0, 31'd0},
        {8'h00,     TYPED, ST_ERR,  KIND_NONE,   1'b0, 31'd0},
        {8'hFF,     TYPED, ST_ERR,  KIND_NONE,   1'b0, 31'd0},
        {CH_DOLLAR, TYPED, ST_RUN,  KIND_BULK,   1'b0, 31'd0},
        {CH_MINUS,  TYPED, ST_RUN,  KIND_BULK,   1'b0, 31'd0},
        {"1",       TYPED, ST_RUN,  KIND_BULK,   1'b0, 31'd0},
        {CH_CR,     TYPED, ST_RUN,  KIND_BULK,   1'b0, 31'd0},
        {CH_LF,     TYPED, ST_DONE, KIND_BULK,   1'b0, 31'd0},
        {CH_STAR,   TYPED, ST_RUN,  KIND_MULTI,  1'b0, 31'd0},
        {"2",       PRED,  NO_RES},
        {CH_CR,     PRED,  NO_RES},
        {CH_LF,     PRED,  NO_RES},
        {CH_DOLLAR, PRED,  NO_RES},
        {CH_MINUS,  PRED,  NO_RES},
        {"1",       PRED,  NO_RES},
        {CH_CR,     PRED,  NO_RES},
        {CH_LF,     PRED,  NO_RES},
        {CH_DOLLAR, PRED,  NO_RES},
        {"0",       PRED,  NO_RES},
        {CH_CR,     PRED,  NO_RES},
        {CH_LF,     PRED,  NO_RES},
        {CH_CR,     PRED,  NO_RES},
        {CH_LF,     PRED,  NO_RES},
        {CH_COLON,  TYPED, ST_RUN,  KIND_INT,    1'b0, 31'd0},
        {CH_MINUS,  TYPED, ST_RUN,  KIND_INT,    1'b0, 31'd0},
        {"x",       TYPED, ST_ERR,  KIND_INT,    1'b0, 31'd0}
    };

    t_phase      ps_phase;
    logic [31:0] ps_accum;
    logic        ps_neg;
    logic        ps_digit;
    logic        ps_cr;
    logic [31:0] ps_elems_left;
    logic [31:0] ps_elem_count;
    logic [31:0] ps_pay_left;
    t_kind       ps_kind;

    t_result     pending_results [$];
    t_row        typed_rows [$];
    logic [7:0]  reply_bytes [$];
    int unsigned mismatches;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned sink_hold;

    function automatic void parser_clear();
        ps_phase      = PH_TYPE;
        ps_accum      = '0;
        ps_neg        = 1'b0;
        ps_digit      = 1'b0;
        ps_cr         = 1'b0;
        ps_elems_left = '0;
        ps_elem_count = '0;
        ps_pay_left   = '0;
        ps_kind       = KIND_NONE;
    endfunction

    function automatic t_status finish_element();
        ps_elem_count = ps_elem_count + 1;
        ps_elems_left = (ps_elems_left != 0) ? ps_elems_left - 1 : '0;
        if (ps_elems_left == 0) return ST_DONE;
        ps_phase = PH_ETYPE;
        return ST_RUN;
    endfunction

    function automatic t_status header_number_byte(input logic [7:0] b);
        logic [63:0] grown;
        logic        negative;
        if (ps_cr) begin
            if (b != CH_LF) return ST_ERR;
            negative = ps_neg && (ps_accum != 0);
            if (ps_phase == PH_ENUM || ps_kind == KIND_BULK) begin
                if (negative) begin
                    if (ps_accum != 1) return ST_ERR;
                    return (ps_phase == PH_ENUM) ? finish_element() : ST_DONE;
                end
                ps_pay_left = ps_accum;
                ps_phase    = (ps_accum != 0) ? PH_PAY : PH_PCR;
                ps_cr       = 1'b0;
                return ST_RUN;
            end
            case (ps_kind)
                KIND_INT: return ST_DONE;
                KIND_MULTI: begin
                    if (negative) return (ps_accum == 1) ? ST_DONE : ST_ERR;
                    if (ps_accum == 0) return ST_DONE;
                    ps_elems_left = ps_accum;
                    ps_elem_count = '0;
                    ps_phase      = PH_ETYPE;
                    ps_accum      = '0;
                    ps_neg        = 1'b0;
                    ps_digit      = 1'b0;
                    ps_cr         = 1'b0;
                    return ST_RUN;
                end
                default: return ST_ERR;
            endcase
        end
        if (b == CH_CR) begin
            if (!ps_digit) return ST_ERR;
            ps_cr = 1'b1;
            return ST_RUN;
        end
        if (b == CH_MINUS && !ps_digit && !ps_neg) begin
            ps_neg = 1'b1;
            return ST_RUN;
        end
        if (b >= CH_ZERO && b <= CH_NINE) begin
            grown = 64'(ps_accum) * 64'd10 + 64'(b - CH_ZERO);
            if (grown > NUM_LIMIT) return ST_ERR;
            ps_accum = grown[31:0];
            ps_digit = 1'b1;
            return ST_RUN;
        end
        return ST_ERR;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result     r;
        t_status     st;
        logic        pay;
        logic [30:0] idx;
        st  = ST_RUN;
        pay = 1'b0;
        idx = (ps_kind == KIND_MULTI && ps_phase != PH_NUM) ? ps_elem_count[30:0] : '0;
        case (ps_phase)
            PH_LINE: begin
                if (ps_cr && b == CH_LF) st = ST_DONE;
                else ps_cr = (b == CH_CR);
            end
            PH_NUM, PH_ENUM: st = header_number_byte(b);
            PH_PAY: begin
                pay         = 1'b1;
                ps_pay_left = (ps_pay_left != 0) ? ps_pay_left - 1 : '0;
                if (ps_pay_left == 0) ps_phase = PH_PCR;
            end
            PH_PCR: begin
                if (b == CH_CR) ps_phase = PH_PLF;
                else st = ST_ERR;
            end
            PH_PLF: begin
                if (b != CH_LF) st = ST_ERR;
                else if (ps_kind == KIND_MULTI) st = finish_element();
                else st = ST_DONE;
            end
            PH_ETYPE: begin
                if (b == CH_DOLLAR) begin
                    ps_accum = '0;
                    ps_neg   = 1'b0;
                    ps_digit = 1'b0;
                    ps_cr    = 1'b0;
                    ps_phase = PH_ENUM;
                end else begin
                    st = ST_ERR;
                end
            end
            default: begin
                parser_clear();
                case (b)
                    CH_PLUS: begin
                        ps_kind  = KIND_STATUS;
                        ps_phase = PH_LINE;
                    end
                    CH_MINUS: begin
                        ps_kind  = KIND_ERROR;
                        ps_phase = PH_LINE;
                    end
                    CH_COLON: begin
                        ps_kind  = KIND_INT;
                        ps_phase = PH_NUM;
                    end
                    CH_DOLLAR: begin
                        ps_kind  = KIND_BULK;
                        ps_phase = PH_NUM;
                    end
                    CH_STAR: begin
                        ps_kind  = KIND_MULTI;
                        ps_phase = PH_NUM;
                    end
                    default: st = ST_ERR;
                endcase
            end
        endcase
        r.status  = st;
        r.kind    = ps_kind;
        r.payload = pay;
        r.index   = idx;
        if (st != ST_RUN) parser_clear();
        return r;
    endfunction

    function automatic void put_crlf();
        reply_bytes.push_back(CH_CR);
        reply_bytes.push_back(CH_LF);
    endfunction

    function automatic void put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) reply_bytes.push_back(s[k]);
    endfunction

    function automatic void put_number(input int unsigned mag, input bit minus);
        if (minus) reply_bytes.push_back(CH_MINUS);
        if ($urandom_range(15) == 0) reply_bytes.push_back(CH_ZERO);
        put_text($sformatf("%0d", mag));
        put_crlf();
    endfunction

    function automatic void put_bulk(input int unsigned len);
        reply_bytes.push_back(CH_DOLLAR);
        put_number(len, 1'b0);
        repeat (len) reply_bytes.push_back(8'($urandom_range(255)));
        put_crlf();
    endfunction

    // Mostly well-formed replies with random content; the rest corrupted, malformed or noise.
    function automatic void build_reply();
        int unsigned pick;
        int unsigned form;
        int unsigned n;
        int unsigned mag;
        logic [7:0]  c;
        logic [7:0]  last;
        reply_bytes.delete();
        pick = $urandom_range(99);
        form = (pick < 80) ? pick : $urandom_range(79);
        last = 8'h00;
        if (pick >= 95) begin
            repeat ($urandom_range(1, 4)) reply_bytes.push_back(8'($urandom_range(255)));
        end else if (pick >= 90) begin
            case ($urandom_range(7))
                0: put_text(":2147483648");
                1: put_text("$99999999999");
                2: put_text("$-2");
                3: put_text("*-5");
                4: begin
                    put_text("*1");
                    put_crlf();
                    put_text("+OK");
                end
                5: put_text("$");
                6: put_text("$--1");
                default: begin
                    put_text("$3");
                    put_crlf();
                    put_text("abcd");
                end
            endcase
            put_crlf();
        end else if (form < 18) begin
            reply_bytes.push_back((form < 10) ? CH_PLUS : CH_MINUS);
            n = $urandom_range(12);
            repeat (n) begin
                c = ($urandom_range(3) == 0) ? CH_CR : 8'($urandom_range(255));
                if (last == CH_CR && c == CH_LF) c = "z";
                reply_bytes.push_back(c);
                last = c;
            end
            put_crlf();
        end else if (form < 30) begin
            reply_bytes.push_back(CH_COLON);
            case ($urandom_range(3))
                0: mag = $urandom_range(999);
                1: mag = $urandom & 32'h7FFF_FFFF;
                2: mag = NUM_LIMIT[31:0];
                default: mag = 0;
            endcase
            put_number(mag, $urandom_range(3) == 0);
        end else if (form < 55) begin
            if ($urandom_range(9) == 0) begin
                put_text("$-1");
                put_crlf();
            end else begin
                put_bulk(($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(12));
            end
        end else begin
            case ($urandom_range(9))
                0: begin
                    put_text("*-1");
                    put_crlf();
                end
                1: begin
                    put_text($urandom_range(1) ? "*0" : "*-0");
                    put_crlf();
                end
                default: begin
                    n = $urandom_range(1, 5);
                    reply_bytes.push_back(CH_STAR);
                    put_number(n, 1'b0);
                    repeat (n) begin
                        if ($urandom_range(5) == 0) begin
                            put_text("$-1");
                            put_crlf();
                        end else begin
                            put_bulk($urandom_range(8));
                        end
                    end
                end
            endcase
        end
        if (pick >= 80 && pick < 90)
            reply_bytes[$urandom_range(reply_bytes.size() - 1)] = 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] value);
        if ($urandom_range(99) < src_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.data_byte <= value;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    always #(PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            rsp.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_row    row;
        if (i_rst_n) begin
            if (req.valid && req.ready) begin
                want = parse_byte(req.data_byte);
                if (typed_rows.size() != 0) begin
                    row = typed_rows.pop_front();
                    if (row.typed) want = row.res;
                end
                pending_results.push_back(want);
            end
            if (rsp.valid && rsp.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no word, got status %0d kind %0d %s %0b index %0d",
                             $time, rsp.parse_status, rsp.reply_kind, "payload",
                             rsp.payload_byte, rsp.element_index);
                end else begin
                    want = pending_results.pop_front();
                    if (want.status !== rsp.parse_status ||
                        want.kind !== rsp.reply_kind ||
                        want.payload !== rsp.payload_byte ||
                        want.index !== rsp.element_index) begin
                        mismatches++;
                        $display("%0t: expected status %0d kind %0d payload %0b index %0d,",
                                 $time, want.status, want.kind, want.payload, want.index);
                        $display("%0t: got status %0d kind %0d payload %0b index %0d",
                                 $time, rsp.parse_status, rsp.reply_kind,
                                 rsp.payload_byte, rsp.element_index);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        int unsigned sent;
        bit          held;
        int          ph;
        int          k;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.data_byte  = 8'h00;
        rsp.ready      = 1'b0;
        mismatches     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = 0;
        parser_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_ROWS; k++) begin
            typed_rows.push_back(script[k]);
            send_byte(script[k].data);
        end

        held = 1'b0;
        for (ph = 0; ph < 4; ph++) begin
            src_idle_pct   = SRC_IDLE[ph];
            sink_stall_pct = SINK_STALL[ph];
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_reply();
                if (ph == 0 && !held && sent > 100) begin
                    sink_hold <= 64;
                    held = 1'b1;
                end
                for (k = 0; k < reply_bytes.size(); k++) send_byte(reply_bytes[k]);
                sent += reply_bytes.size();
            end
        end
        req.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* resp_reply_parser.f */
design/rrp_pkg.sv
design/rrp_in_if.sv
design/rrp_out_if.sv
design/rrp_digit.sv
design/rrp_fsm.sv
design/resp_reply_parser.sv
test/tb.sv
